@@ rtl/core/cdss_pkg.sv @@
// Shared constants, codes and types for the circular disk-scan scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cdss_pkg;

   localparam int MAX_REQ  = 32;
   localparam int COUNT_W  = $clog2(MAX_REQ + 1);
   localparam int CYL_W    = 16;
   localparam int KEY_W    = CYL_W + 1;
   localparam int MOVE_W   = 18;
   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 17;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = SIZE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISK_SIZE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_START    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CIRCULAR_SCAN = 2'd2;

   localparam logic [SIZE_W-1:0] DISK_SIZE_RESET = 17'h10000;
   localparam logic [SIZE_W-1:0] DISK_SIZE_MAX   = 17'h10000;

   localparam logic [KIND_W-1:0] KIND_HEAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ZERO = 2'd3;

   // sort key: top bit set for requests below the head, low bits the cylinder
   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_HEAD  = 6'b000010,
      ST_UPPER = 6'b000100,
      ST_END   = 6'b001000,
      ST_ZERO  = 6'b010000,
      ST_LOWER = 6'b100000
   } seq_state_type;

endpackage

`default_nettype wire

@@ rtl/core/cdss_stream_if.sv @@
// Valid/ready channel interfaces for requests and visit results.
// Depends on cdss_pkg for field widths.
`default_nettype none

interface cdss_req_if import cdss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CYL_W-1:0] cylinder;
   logic             batch_last;

   modport source (output valid, output cylinder, output batch_last, input ready);
   modport sink   (input valid, input cylinder, input batch_last, output ready);
endinterface

interface cdss_rsp_if import cdss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CYL_W-1:0]  position;
   logic [KIND_W-1:0] stop_kind;
   logic [MOVE_W-1:0] movement_so_far;
   logic              sequence_last;

   modport source (output valid, output position, output stop_kind,
                   output movement_so_far, output sequence_last, input ready);
   modport sink   (input valid, input position, input stop_kind,
                   input movement_so_far, input sequence_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdss_cell.sv @@
// One slot of the sorted request chain: holds a key, inserts or shifts.
// Depends on cdss_pkg.
`default_nettype none

module cdss_cell import cdss_pkg::*; (
   input  wire          clock,
   input  cell_ctl_type ctl,
   input  key_type      new_key,
   input  wire          occupied,
   input  wire          prev_gt,
   input  key_type      prev_key,
   input  key_type      next_key,
   output key_type      key,
   output logic         gt
);

   key_type key_ff, key_in;

   // empty slots count as larger than any key
   assign gt  = !occupied || (key_ff > new_key);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.insert && gt) begin
         key_in = prev_gt ? prev_key : new_key;
      end else if (ctl.pop) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/cdss_chain.sv @@
// Row of sorting cells: insertion shifts larger keys up, a pop shifts all down.
// Depends on cdss_pkg and cdss_cell.
`default_nettype none

module cdss_chain import cdss_pkg::*; (
   input  wire                clock,
   input  cell_ctl_type       ctl,
   input  key_type            new_key,
   input  wire  [COUNT_W-1:0] count,
   output key_type            head_key
);

   key_type key_w [MAX_REQ];
   logic    gt_w  [MAX_REQ];

   for (genvar i = 0; i < MAX_REQ; i++) begin : g_cell
      logic    occ;
      logic    pgt;
      key_type pkey;
      key_type nkey;

      assign occ = (COUNT_W'(i) < count);

      if (i == 0) begin : g_first
         assign pgt  = 1'b0;
         assign pkey = '0;
      end else begin : g_mid
         assign pgt  = gt_w[i-1];
         assign pkey = key_w[i-1];
      end

      if (i == MAX_REQ - 1) begin : g_last
         assign nkey = '0;
      end else begin : g_inner
         assign nkey = key_w[i+1];
      end

      cdss_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .new_key  (new_key),
         .occupied (occ),
         .prev_gt  (pgt),
         .prev_key (pkey),
         .next_key (nkey),
         .key      (key_w[i]),
         .gt       (gt_w[i])
      );
   end

   assign head_key = key_w[0];

endmodule

`default_nettype wire

@@ rtl/core/circular_disk_scan_scheduler.sv @@
// Top level of the C-SCAN / C-LOOK scheduler: config registers, visit sequencer,
// output register. Depends on cdss_pkg, cdss_stream_if and cdss_chain.
//
//   channel   | dir | handshake     | payload
//   req_chan  | in  | valid/ready   | cylinder, batch_last
//   rsp_chan  | out | valid/ready   | position, stop_kind, movement_so_far, sequence_last
//   csr_*     | in  | csr_write     | csr_index, csr_data
//
// Loading takes one request per cycle; the cell chain inserts in place in that cycle.
// A batch of N stored requests then emits N+1 to N+3 results, one per cycle while rsp
// is free, plus sequencer steps that emit nothing; no request is taken then.
// A stalled rsp_chan holds the output register and freezes the sequencer.
// Reset is synchronous; it clears count and sequencer, presets config; no clearing pass.
`default_nettype none

module circular_disk_scan_scheduler import cdss_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_write,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data,
   cdss_req_if.sink               req_chan,
   cdss_rsp_if.source             rsp_chan
);

   logic [SIZE_W-1:0]  disk_size_ff;
   logic [CYL_W-1:0]   head_start_ff;
   logic               circ_ff;

   seq_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               any_upper_ff, any_upper_in;
   logic [CYL_W-1:0]   last_upper_ff, last_upper_in;
   logic [CYL_W-1:0]   cur_ff, cur_in;
   logic [MOVE_W-1:0]  mov_ff, mov_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CYL_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [MOVE_W-1:0]  rsp_mov_ff, rsp_mov_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_ctl_type       ctl;
   key_type            new_key;
   key_type            head_key;
   logic [CYL_W-1:0]   end_cyl;
   logic               slot_free;
   logic               accept;
   logic               emit;
   logic               emit_first;
   logic [CYL_W-1:0]   emit_pos;
   logic [KIND_W-1:0]  emit_kind;
   logic               emit_last;
   logic [CYL_W-1:0]   seek_dist;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         disk_size_ff  <= DISK_SIZE_RESET;
         head_start_ff <= '0;
         circ_ff       <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DISK_SIZE:     disk_size_ff  <= csr_data;
            CSR_HEAD_START:    head_start_ff <= csr_data[CYL_W-1:0];
            CSR_CIRCULAR_SCAN: circ_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp the disk size to 1..65536 and take the highest cylinder
   always_comb begin
      if (disk_size_ff == '0) begin
         end_cyl = '0;
      end else if (disk_size_ff >= DISK_SIZE_MAX) begin
         end_cyl = '1;
      end else begin
         end_cyl = disk_size_ff[CYL_W-1:0] - CYL_W'(1);
      end
   end

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign accept         = req_chan.valid && req_chan.ready;
   assign new_key        = {req_chan.cylinder < head_start_ff, req_chan.cylinder};
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      any_upper_in  = any_upper_ff;
      last_upper_in = last_upper_ff;
      ctl           = '0;
      emit          = 1'b0;
      emit_first    = 1'b0;
      emit_pos      = '0;
      emit_kind     = KIND_REQ;
      emit_last     = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               // drop the request when the chain is full
               if (count_ff < COUNT_W'(MAX_REQ)) begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + COUNT_W'(1);
               end
               if (req_chan.batch_last) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               emit         = 1'b1;
               emit_first   = 1'b1;
               emit_pos     = head_start_ff;
               emit_kind    = KIND_HEAD;
               emit_last    = (count_ff == '0) && !circ_ff;
               any_upper_in = 1'b0;
               state_in     = ST_UPPER;
            end
         end
         ST_UPPER: begin
            if (slot_free) begin
               if (count_ff != '0 && !head_key[KEY_W-1]) begin
                  emit          = 1'b1;
                  emit_pos      = head_key[CYL_W-1:0];
                  emit_last     = (count_ff == COUNT_W'(1)) && !circ_ff;
                  ctl.pop       = 1'b1;
                  count_in      = count_ff - COUNT_W'(1);
                  any_upper_in  = 1'b1;
                  last_upper_in = head_key[CYL_W-1:0];
               end else begin
                  state_in = circ_ff ? ST_END : ST_LOWER;
               end
            end
         end
         ST_END: begin
            if (slot_free) begin
               if (any_upper_ff && last_upper_ff != end_cyl) begin
                  emit      = 1'b1;
                  emit_pos  = end_cyl;
                  emit_kind = KIND_END;
               end
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_pos  = '0;
               emit_kind = KIND_ZERO;
               emit_last = (count_ff == '0);
               state_in  = ST_LOWER;
            end
         end
         ST_LOWER: begin
            if (count_ff == '0) begin
               state_in = ST_LOAD;
            end else if (slot_free) begin
               emit      = 1'b1;
               emit_pos  = head_key[CYL_W-1:0];
               emit_last = (count_ff == COUNT_W'(1));
               ctl.pop   = 1'b1;
               count_in  = count_ff - COUNT_W'(1);
               if (count_ff == COUNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // running head movement
   assign seek_dist = (emit_pos > cur_ff) ? (emit_pos - cur_ff) : (cur_ff - emit_pos);

   always_comb begin
      cur_in       = cur_ff;
      mov_in       = mov_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_mov_in   = rsp_mov_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         cur_in       = emit_pos;
         mov_in       = emit_first ? '0 : mov_ff + MOVE_W'(seek_dist);
         rsp_valid_in = 1'b1;
         rsp_pos_in   = emit_pos;
         rsp_kind_in  = emit_kind;
         rsp_mov_in   = mov_in;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         any_upper_ff <= 1'b0;
         mov_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         any_upper_ff <= any_upper_in;
         mov_ff       <= mov_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_upper_ff <= last_upper_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_mov_ff    <= rsp_mov_in;
      rsp_last_ff   <= rsp_last_in;
   end

   cdss_chain u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .new_key  (new_key),
      .count    (count_ff),
      .head_key (head_key)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.position        = rsp_pos_ff;
   assign rsp_chan.stop_kind       = rsp_kind_ff;
   assign rsp_chan.movement_so_far = rsp_mov_ff;
   assign rsp_chan.sequence_last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_REQ))
      else $error("request count beyond chain depth");

   a_last_starts_seq: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.batch_last |=> state_ff == ST_HEAD)
      else $error("final request did not start the visit sequence");

   a_head_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_HEAD |-> rsp_mov_ff == '0)
      else $error("head start result carries movement");

   a_count_no_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |=> count_ff <= $past(count_ff))
      else $error("request count grew while emitting");

endmodule

`default_nettype wire

@@ dv/circular_disk_scan_scheduler_test.sv @@
// Self-checking testbench for the C-SCAN / C-LOOK disk scheduler: directed batches,
// then random batches under several sender and receiver idling mixes.
// Depends on cdss_pkg, cdss_stream_if and the circular_disk_scan_scheduler RTL.
`default_nettype none

module circular_disk_scan_scheduler_test;
   import cdss_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 100;

   typedef struct packed {
      logic [CYL_W-1:0]  position;
      logic [KIND_W-1:0] kind;
      logic [MOVE_W-1:0] movement;
      logic              last;
   } visit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic receiver_ready = 1'b0;

   cdss_req_if req_if ();
   cdss_rsp_if rsp_if ();

   assign rsp_if.ready = receiver_ready;

   circular_disk_scan_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // scheduler state as the testbench sees it
   logic [SIZE_W-1:0] disk_size_reg = DISK_SIZE_RESET;
   logic [CYL_W-1:0] head_reg = '0;
   logic scan_reg = 1'b1;
   key_type pending_keys [MAX_REQ];
   int pending_count = 0;
   logic [CYL_W-1:0] track_pos = '0;
   logic [MOVE_W-1:0] track_move = '0;
   visit_type expected_visits [$];

   int gap_pct = 0;
   int stall_pct = 0;
   int sent_items = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   logic [CYL_W-1:0] last_cylinder = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) receiver_ready <= ($urandom_range(99) >= stall_pct);

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch: %s", what);
   endtask

   function automatic logic [SIZE_W-1:0] effective_disk_size();
      if (disk_size_reg == '0) return SIZE_W'(1);
      if (disk_size_reg > DISK_SIZE_MAX) return DISK_SIZE_MAX;
      return disk_size_reg;
   endfunction

   function automatic void add_visit(input logic [CYL_W-1:0] pos,
                                     input logic [KIND_W-1:0] kind, input bit is_start);
      visit_type v;
      logic [CYL_W-1:0] seek;
      if (!is_start) begin
         seek = (pos > track_pos) ? pos - track_pos : track_pos - pos;
         track_move = track_move + MOVE_W'(seek);
      end
      track_pos = pos;
      v.position = pos;
      v.kind = kind;
      v.movement = track_move;
      v.last = 1'b0;
      expected_visits.push_back(v);
   endfunction

   // insert one request in sort order; on the batch end, build the whole visit sequence
   function automatic void schedule_request(input logic [CYL_W-1:0] cyl, input logic batch_end);
      key_type key;
      int p;
      int i;
      logic [CYL_W-1:0] end_cyl;
      logic [CYL_W-1:0] last_upper;
      bit any_upper;
      if (pending_count < MAX_REQ) begin
         key = (cyl < head_reg) ? {1'b1, cyl} : {1'b0, cyl};
         p = pending_count;
         while (p > 0 && pending_keys[p-1] > key) begin
            pending_keys[p] = pending_keys[p-1];
            p--;
         end
         pending_keys[p] = key;
         pending_count++;
      end
      if (!batch_end) return;
      end_cyl = CYL_W'(effective_disk_size() - 1);
      track_move = '0;
      any_upper = 1'b0;
      last_upper = '0;
      add_visit(head_reg, KIND_HEAD, 1'b1);
      i = 0;
      while (i < pending_count && !pending_keys[i][KEY_W-1]) begin
         add_visit(pending_keys[i][CYL_W-1:0], KIND_REQ, 1'b0);
         any_upper = 1'b1;
         last_upper = pending_keys[i][CYL_W-1:0];
         i++;
      end
      if (scan_reg) begin
         if (any_upper && last_upper != end_cyl) add_visit(end_cyl, KIND_END, 1'b0);
         add_visit('0, KIND_ZERO, 1'b0);
      end
      for (; i < pending_count; i++) add_visit(pending_keys[i][CYL_W-1:0], KIND_REQ, 1'b0);
      expected_visits[expected_visits.size()-1].last = 1'b1;
      pending_count = 0;
   endfunction

   always @(posedge clock) begin : check_visits
      visit_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_visits.size() == 0) begin
            report_mismatch($sformatf("unexpected visit at cylinder %0d", rsp_if.position));
         end else begin
            want = expected_visits.pop_front();
            if (rsp_if.position !== want.position)
               report_mismatch($sformatf("position %0d, want %0d",
                                         rsp_if.position, want.position));
            if (rsp_if.stop_kind !== want.kind)
               report_mismatch($sformatf("stop_kind %0d at %0d, want %0d",
                                         rsp_if.stop_kind, want.position, want.kind));
            if (rsp_if.movement_so_far !== want.movement)
               report_mismatch($sformatf("movement %0d at %0d, want %0d",
                                         rsp_if.movement_so_far, want.position, want.movement));
            if (rsp_if.sequence_last !== want.last)
               report_mismatch($sformatf("sequence_last %0b at %0d, want %0b",
                                         rsp_if.sequence_last, want.position, want.last));
         end
      end
   end

   task automatic send_request(input logic [CYL_W-1:0] cyl, input logic batch_end);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cylinder <= cyl;
      req_if.batch_last <= batch_end;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      schedule_request(cyl, batch_end);
      last_cylinder = cyl;
      sent_items++;
   endtask

   // drop valid, wait for every expected visit, then let the sequencer settle
   task automatic wait_until_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_DISK_SIZE:     disk_size_reg = value;
         CSR_HEAD_START:    head_reg = value[CYL_W-1:0];
         CSR_CIRCULAR_SCAN: scan_reg = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [CYL_W-1:0] pick_cylinder();
      logic [SIZE_W-1:0] size;
      size = effective_disk_size();
      case ($urandom_range(9))
         0, 1, 2, 3: return CYL_W'($urandom);
         4, 5:       return CYL_W'($urandom_range(size - 1));
         6:          return head_reg + CYL_W'($urandom_range(6)) - CYL_W'(3);
         7: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return '1;
               2:       return CYL_W'(size - 1);
               default: return CYL_W'(size);
            endcase
         end
         default:    return last_cylinder;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_disk_size();
      case ($urandom_range(9))
         0:          return '0;
         1:          return CSR_DATA_W'(1);
         2:          return DISK_SIZE_MAX;
         3:          return CSR_DATA_W'($urandom_range(131071, 65537));
         4, 5, 6:    return CSR_DATA_W'($urandom_range(256, 2));
         default:    return CSR_DATA_W'($urandom_range(65535, 2));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_head();
      case ($urandom_range(9))
         0:          return '0;
         1:          return CSR_DATA_W'(16'hFFFF);
         2, 3, 4, 5: return CSR_DATA_W'($urandom_range(effective_disk_size() - 1));
         default:    return CSR_DATA_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic int pick_batch_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(6, 1);
      if (r < 90) return $urandom_range(31, 7);
      if (r < 97) return MAX_REQ;
      return $urandom_range(MAX_REQ + 8, MAX_REQ + 1);
   endfunction

   task automatic send_batch(input int len);
      int split;
      split = ($urandom_range(9) == 0 && len > 1) ? $urandom_range(len - 1, 1) : -1;
      for (int k = 0; k < len; k++) begin
         if (k == split) begin
            wait_until_idle();
            write_register(CSR_HEAD_START, pick_head());
         end
         send_request(pick_cylinder(), k == len - 1);
      end
   endtask

   task automatic test_reset_registers();
      send_request(16'd0, 1'b1);
      send_request(16'hFFFF, 1'b1);
   endtask

   task automatic test_scan_modes();
      wait_until_idle();
      write_register(CSR_DISK_SIZE, 17'd5000);
      write_register(CSR_HEAD_START, 17'd1000);
      write_register(CSR_CIRCULAR_SCAN, 17'd0);
      send_request(16'd1200, 1'b0);
      send_request(16'd999, 1'b0);
      send_request(16'd1000, 1'b0);
      send_request(16'd0, 1'b0);
      send_request(16'd4999, 1'b1);
      wait_until_idle();
      write_register(CSR_CIRCULAR_SCAN, 17'd1);
      send_request(16'd1200, 1'b0);
      send_request(16'd999, 1'b0);
      send_request(16'd1000, 1'b0);
      send_request(16'd0, 1'b0);
      send_request(16'd4999, 1'b1);
      // lower requests only: no end stop, still the wrap
      send_request(16'd5, 1'b1);
      send_request(16'd4000, 1'b1);
   endtask

   task automatic test_disk_size_limits();
      wait_until_idle();
      write_register(CSR_DISK_SIZE, 17'd0);
      write_register(CSR_HEAD_START, 17'd0);
      // beyond the disk end; end stop falls on cylinder zero
      send_request(16'hFFFF, 1'b1);
      send_request(16'd0, 1'b1);
      wait_until_idle();
      write_register(CSR_DISK_SIZE, 17'h1FFFF);
      send_request(16'd100, 1'b1);
      wait_until_idle();
      write_register(CSR_DISK_SIZE, 17'd1);
      send_request(16'd7, 1'b1);
      wait_until_idle();
      write_register(CSR_DISK_SIZE, DISK_SIZE_MAX);
      write_register(CSR_HEAD_START, 17'hFFFF);
      send_request(16'hFFFF, 1'b0);
      send_request(16'd3, 1'b1);
   endtask

   task automatic test_head_change_mid_batch();
      wait_until_idle();
      write_register(CSR_DISK_SIZE, 17'd1000);
      write_register(CSR_HEAD_START, 17'd500);
      send_request(16'd400, 1'b0);
      send_request(16'd600, 1'b0);
      wait_until_idle();
      write_register(CSR_HEAD_START, 17'd300);
      send_request(16'd350, 1'b0);
      send_request(16'd200, 1'b1);
   endtask

   task automatic test_store_overflow();
      wait_until_idle();
      write_register(CSR_DISK_SIZE, DISK_SIZE_MAX);
      write_register(CSR_HEAD_START, 17'd30000);
      for (int k = 0; k < MAX_REQ + 2; k++) send_request(CYL_W'($urandom), 1'b0);
      // the final request is dropped but still starts the sequence
      send_request(16'd12345, 1'b1);
   endtask

   task automatic test_random_batches();
      int gap_plan [4];
      int stall_plan [4];
      int goal;
      int ph;
      gap_plan = '{0, 78, 0, 31};
      stall_plan = '{0, 0, 78, 31};
      for (ph = 0; ph < 4; ph++) begin
         gap_pct = gap_plan[ph];
         stall_pct = stall_plan[ph];
         goal = sent_items + PHASE_ITEMS;
         while (sent_items < goal) begin
            if ($urandom_range(99) < 30) begin
               wait_until_idle();
               write_register(CSR_DISK_SIZE, pick_disk_size());
               write_register(CSR_HEAD_START, pick_head());
               write_register(CSR_CIRCULAR_SCAN, CSR_DATA_W'($urandom_range(1)));
            end
            send_batch(pick_batch_length());
         end
      end
      gap_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.cylinder <= '0;
      req_if.batch_last <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_registers();
      test_scan_modes();
      test_disk_size_limits();
      test_head_change_mid_batch();
      test_store_overflow();
      test_random_batches();
      wait_until_idle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
